// ===== rtl/efd_pkg.sv =====
`default_nettype none

package efd_pkg;

  localparam int MAX_CHIPS_DEF = 4;
  localparam int CHANS_PER_CHIP_DEF = 8;
  localparam int TIMESTAMP_BYTES_DEF = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam int CFG_DATA_W = 32;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_CHIP_COUNT = 1'd0;
  localparam cfg_idx_t REG_SCALE = 1'd1;

  localparam logic [2:0] CHIP_COUNT_RESET = 3'd1;

  // last byte positions within a field
  localparam logic [2:0] SEQ_LAST = 3'd3;
  localparam logic [2:0] WORD24_LAST = 3'd2;

  typedef enum logic [1:0] {
    PH_SEQ,
    PH_TIME,
    PH_STATUS,
    PH_SAMPLE
  } phase_t;

  typedef enum logic [1:0] {
    REC_HEADER,
    REC_STATUS,
    REC_CHANNEL
  } rec_type_t;

  typedef struct packed {
    rec_type_t          record_type;
    logic [31:0]        sequence_number;
    logic [63:0]        time_stamp;
    logic signed [31:0] dropped_count;
    logic [1:0]         chip_index;
    logic [7:0]         lead_off_bits;
    logic [2:0]         channel_index;
    logic signed [23:0] raw_sample;
    logic               frame_end;
  } rec_t;

  typedef struct packed {
    rec_t               rec;
    logic signed [39:0] micro_volts;
  } out_rec_t;

endpackage

`default_nettype wire

// ===== rtl/efd_front.sv =====
`default_nettype none

module efd_front #(
  parameter int MAX_CHIPS = efd_pkg::MAX_CHIPS_DEF,
  parameter int CHANS_PER_CHIP = efd_pkg::CHANS_PER_CHIP_DEF,
  parameter int TIMESTAMP_BYTES = efd_pkg::TIMESTAMP_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_acc,
  input  wire logic [7:0]  in_byte,
  input  wire logic [2:0]  chip_count,
  output logic             rec_v,
  output efd_pkg::rec_t    rec
);
  import efd_pkg::*;

  localparam int TS_W = 8 * TIMESTAMP_BYTES;
  localparam int ASM_BYTES = (TIMESTAMP_BYTES > 4) ? TIMESTAMP_BYTES : 4;
  localparam int ASM_W = 8 * ASM_BYTES;
  localparam int CHIP_W = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
  localparam int ACT_W = 5;
  localparam logic [2:0] TS_LAST = 3'(TIMESTAMP_BYTES - 1);
  localparam logic [2:0] CH_LAST = 3'(CHANS_PER_CHIP - 1);
  localparam logic [ACT_W-1:0] MAX_ACT = ACT_W'(MAX_CHIPS);

  phase_t             phase_r, phase_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [ASM_W-1:0]   asm_r, asm_nxt;
  logic [CHIP_W-1:0]  chip_r, chip_nxt;
  logic [2:0]         chan_r, chan_nxt;
  logic [31:0]        seq_r, seq_nxt;
  logic [31:0]        prev_r, prev_nxt;
  logic [TS_W-1:0]    ts_r, ts_nxt;

  logic [ASM_W-1:0]   asm_le;
  logic [23:0]        word24;
  logic [ACT_W-1:0]   active;
  logic               last_chip;

  always_comb begin
    asm_le = asm_r;
    for (int i = 0; i < ASM_BYTES; i++) begin
      if (cnt_r == 3'(i)) begin
        asm_le[8*i +: 8] = in_byte;
      end
    end
  end

  assign word24 = {asm_r[15:0], in_byte};

  // zero chips counts as one, saturate at the build limit
  always_comb begin
    if (chip_count == 3'd0) begin
      active = ACT_W'(1);
    end else if (ACT_W'(chip_count) > MAX_ACT) begin
      active = MAX_ACT;
    end else begin
      active = ACT_W'(chip_count);
    end
  end

  assign last_chip = (ACT_W'(chip_r) + ACT_W'(1)) >= active;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    asm_nxt = asm_r;
    chip_nxt = chip_r;
    chan_nxt = chan_r;
    seq_nxt = seq_r;
    prev_nxt = prev_r;
    ts_nxt = ts_r;
    rec_v = 1'b0;
    rec = '0;
    rec.sequence_number = seq_r;
    rec.time_stamp = 64'(ts_r);
    if (in_acc) begin
      unique case (phase_r)
        PH_SEQ: begin
          asm_nxt = asm_le;
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == SEQ_LAST) begin
            seq_nxt = asm_le[31:0];
            cnt_nxt = 3'd0;
            phase_nxt = PH_TIME;
          end
        end
        PH_TIME: begin
          asm_nxt = asm_le;
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == TS_LAST) begin
            ts_nxt = asm_le[TS_W-1:0];
            cnt_nxt = 3'd0;
            chip_nxt = '0;
            chan_nxt = 3'd0;
            phase_nxt = PH_STATUS;
            prev_nxt = seq_r;
            rec_v = 1'b1;
            rec.record_type = REC_HEADER;
            rec.time_stamp = 64'(asm_le[TS_W-1:0]);
            rec.dropped_count = seq_r - prev_r - 32'd1;
          end
        end
        PH_STATUS: begin
          asm_nxt[23:0] = word24;
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == WORD24_LAST) begin
            cnt_nxt = 3'd0;
            chan_nxt = 3'd0;
            phase_nxt = PH_SAMPLE;
            rec_v = 1'b1;
            rec.record_type = REC_STATUS;
            rec.chip_index = 2'(chip_r);
            rec.lead_off_bits = word24[19:12];
          end
        end
        PH_SAMPLE: begin
          asm_nxt[23:0] = word24;
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == WORD24_LAST) begin
            cnt_nxt = 3'd0;
            rec_v = 1'b1;
            rec.record_type = REC_CHANNEL;
            rec.chip_index = 2'(chip_r);
            rec.channel_index = chan_r;
            rec.raw_sample = word24;
            if (chan_r == CH_LAST) begin
              chan_nxt = 3'd0;
              if (last_chip) begin
                rec.frame_end = 1'b1;
                chip_nxt = '0;
                phase_nxt = PH_SEQ;
              end else begin
                chip_nxt = chip_r + CHIP_W'(1);
                phase_nxt = PH_STATUS;
              end
            end else begin
              chan_nxt = chan_r + 3'd1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEQ;
      cnt_r <= 3'd0;
      asm_r <= '0;
      chip_r <= '0;
      chan_r <= 3'd0;
      seq_r <= 32'd0;
      prev_r <= 32'd0;
      ts_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
      asm_r <= asm_nxt;
      chip_r <= chip_nxt;
      chan_r <= chan_nxt;
      seq_r <= seq_nxt;
      prev_r <= prev_nxt;
      ts_r <= ts_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/efd_queue.sv =====
`default_nettype none

module efd_queue #(
  parameter int DEPTH = efd_pkg::QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  efd_pkg::rec_t din,
  input  wire logic     pop,
  output efd_pkg::rec_t dout,
  output logic          full,
  output logic          empty
);
  import efd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  rec_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full = cnt_r == CNT_W'(DEPTH);
  assign empty = cnt_r == '0;
  assign dout = mem_r[rd_r];

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/efd_back.sv =====
`default_nettype none

module efd_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] scale,
  input  wire logic        q_empty,
  input  efd_pkg::rec_t    q_head,
  output logic             q_pop,
  input  wire logic        out_pop,
  output logic             out_empty,
  output efd_pkg::out_rec_t out_head
);
  import efd_pkg::*;

  localparam int DEPTH = OUT_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  rec_t               stage_r;
  logic               stage_v_r;
  logic signed [56:0] prod;
  logic [CNT_W:0]     credit;

  out_rec_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt;
  logic [PTR_W-1:0]   rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pop_acc;

  // pull a word only when the output queue has room for it and the one in flight
  assign credit = {1'b0, cnt_r} + (CNT_W + 1)'(stage_v_r);
  assign q_pop = !q_empty && (credit < (CNT_W + 1)'(DEPTH));

  assign prod = $signed(stage_r.raw_sample) * $signed({1'b0, scale});

  assign pop_acc = out_pop && !out_empty;
  assign out_empty = cnt_r == '0;
  assign out_head = mem_r[rd_r];

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    cnt_nxt = cnt_r;
    if (stage_v_r) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop_acc) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + PTR_W'(1);
    end
    if (stage_v_r && !pop_acc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop_acc && !stage_v_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      stage_r <= q_head;
    end
    if (stage_v_r) begin
      mem_r[wr_r] <= '{rec: stage_r, micro_volts: prod[55:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      stage_v_r <= q_pop;
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eeg_frame_deframer.sv =====
// Channel  Direction  Handshake          Payload
// in_      input      push / full        data_byte
// out_     output     empty / pop        record_type .. frame_end, micro_volts
// cfg_     input      we (no wait)       index, data (chip_count, scale_q16_16)
//
// One byte is taken every cycle while full is low; in_full rises only when the
// four-entry record queue between decoder and scaler is full.
// A record reaches the out_ ports through three registered steps after the byte that completes it
// (decode into the queue, queue to multiply stage, multiply into output queue).
// Reset is synchronous and empties both queues; the decoder restarts at a sequence number.
// A stalled output fills the output queue, then the record queue, then raises in_full.
`default_nettype none

module eeg_frame_deframer #(
  parameter int MAX_CHIPS = efd_pkg::MAX_CHIPS_DEF,
  parameter int CHANS_PER_CHIP = efd_pkg::CHANS_PER_CHIP_DEF,
  parameter int TIMESTAMP_BYTES = efd_pkg::TIMESTAMP_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic [7:0]                 in_data_byte,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output logic [1:0]                      out_record_type,
  output logic [31:0]                     out_sequence_number,
  output logic [63:0]                     out_time_stamp,
  output logic signed [31:0]              out_dropped_count,
  output logic [1:0]                      out_chip_index,
  output logic [7:0]                      out_lead_off_bits,
  output logic [2:0]                      out_channel_index,
  output logic signed [23:0]              out_raw_sample,
  output logic signed [39:0]              out_micro_volts,
  output logic                            out_frame_end,
  input  wire logic                       cfg_we,
  input  efd_pkg::cfg_idx_t               cfg_index,
  input  wire logic [efd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import efd_pkg::*;

  logic [2:0]  chip_count_r;
  logic [31:0] scale_r;

  logic        in_acc;
  logic        rec_v;
  rec_t        rec;
  rec_t        q_head;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  out_rec_t    out_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_count_r <= CHIP_COUNT_RESET;
      scale_r <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHIP_COUNT: chip_count_r <= cfg_data[2:0];
        REG_SCALE:      scale_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign in_full = q_full;
  assign in_acc = in_push && !q_full;

  efd_front #(
    .MAX_CHIPS(MAX_CHIPS),
    .CHANS_PER_CHIP(CHANS_PER_CHIP),
    .TIMESTAMP_BYTES(TIMESTAMP_BYTES)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_acc(in_acc),
    .in_byte(in_data_byte),
    .chip_count(chip_count_r),
    .rec_v(rec_v),
    .rec(rec)
  );

  efd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(rec_v),
    .din(rec),
    .pop(q_pop),
    .dout(q_head),
    .full(q_full),
    .empty(q_empty)
  );

  efd_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .scale(scale_r),
    .q_empty(q_empty),
    .q_head(q_head),
    .q_pop(q_pop),
    .out_pop(out_pop),
    .out_empty(out_empty),
    .out_head(out_head)
  );

  assign out_record_type = out_head.rec.record_type;
  assign out_sequence_number = out_head.rec.sequence_number;
  assign out_time_stamp = out_head.rec.time_stamp;
  assign out_dropped_count = out_head.rec.dropped_count;
  assign out_chip_index = out_head.rec.chip_index;
  assign out_lead_off_bits = out_head.rec.lead_off_bits;
  assign out_channel_index = out_head.rec.channel_index;
  assign out_raw_sample = out_head.rec.raw_sample;
  assign out_micro_volts = out_head.micro_volts;
  assign out_frame_end = out_head.rec.frame_end;

`ifndef ASSERT_OFF
  a_reset_drains: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_record_type == REC_HEADER) |->
      (out_chip_index == 2'd0 && out_raw_sample == 24'sd0 && out_micro_volts == 40'sd0))
    else $error("header word carries sample fields");

  a_frame_end_on_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_end) |-> (out_record_type == REC_CHANNEL))
    else $error("frame end flagged on a non-channel word");
`endif

endmodule

`default_nettype wire
